// ===== design/tr_pkg.sv =====
// Shared types and codes of the texture resampler.
`timescale 1ns / 1ps
`default_nettype none

package tr_pkg;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic FMT_ARGB8888 = 1'b0;
    localparam logic FMT_A1R5G5B5 = 1'b1;

    localparam logic FILT_NEAREST  = 1'b0;
    localparam logic FILT_BILINEAR = 1'b1;

    localparam logic [2:0] CFG_PIXEL_FORMAT = 3'd0;
    localparam logic [2:0] CFG_FILTER_MODE  = 3'd1;
    localparam logic [2:0] CFG_SRC_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_SRC_HEIGHT   = 3'd3;
    localparam logic [2:0] CFG_DST_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_DST_HEIGHT   = 3'd5;

    typedef enum logic [1:0] {
        SETUP_IDLE,
        SETUP_LOAD,
        SETUP_RUN
    } setup_state_t;

    typedef enum logic [1:0] {
        JOB_SCALE_X,
        JOB_SCALE_Y,
        JOB_RECIP_X,
        JOB_RECIP_Y
    } setup_job_t;

    typedef struct packed {
        logic        opcode;
        logic [9:0]  coord_x;
        logic [9:0]  coord_y;
        logic [31:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic [9:0]  out_x;
        logic [9:0]  out_y;
        logic        range_error;
    } out_item_t;

    typedef struct packed {
        logic        is_sample;
        logic        load_ok;
        logic        fmt16;
        logic        range_error;
        logic [9:0]  coord_x;
        logic [9:0]  coord_y;
        logic [31:0] pixel;
    } meta_t;

endpackage

`default_nettype wire

// ===== design/tr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/tr_setup.sv =====
// Sequential divider that derives the scale factors and reciprocals from the sizes.
`timescale 1ns / 1ps
`default_nettype none

module tr_setup #(
    parameter int SZW = 9,
    parameter int DDW = 11,
    parameter int SCB = 25,
    parameter int RB  = 31,
    parameter int K   = 30
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           restart,
    input  wire logic [SZW-1:0] sw,
    input  wire logic [SZW-1:0] sh,
    input  wire logic [DDW-1:0] dw,
    input  wire logic [DDW-1:0] dh,
    output logic      [SCB-1:0] scale_x,
    output logic      [SCB-1:0] scale_y,
    output logic      [RB-1:0]  recip_x,
    output logic      [RB-1:0]  recip_y,
    output logic                busy
);

    localparam int DVW  = (RB > SCB) ? RB : SCB;
    localparam int CNTW = $clog2(DVW + 1);

    tr_pkg::setup_state_t state_reg, state_next;
    tr_pkg::setup_job_t   job_reg, job_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DVW-1:0]  dvd_reg, dvd_next;
    logic [DDW:0]    rem_reg, rem_next;
    logic [DDW-1:0]  dsr_reg, dsr_next;
    logic [SCB-1:0]  scale_x_reg, scale_x_next, scale_y_reg, scale_y_next;
    logic [RB-1:0]   recip_x_reg, recip_x_next, recip_y_reg, recip_y_next;
    logic [DDW:0]    trial;
    logic            ge;
    logic [DVW-1:0]  quot;

    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        cnt_next     = cnt_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        dsr_next     = dsr_reg;
        scale_x_next = scale_x_reg;
        scale_y_next = scale_y_reg;
        recip_x_next = recip_x_reg;
        recip_y_next = recip_y_reg;
        trial        = {rem_reg[DDW-1:0], dvd_reg[DVW-1]};
        ge           = trial >= {1'b0, dsr_reg};
        quot         = {dvd_reg[DVW-2:0], ge};
        case (state_reg)
            tr_pkg::SETUP_LOAD: begin
                rem_next = '0;
                cnt_next = '0;
                case (job_reg)
                    tr_pkg::JOB_SCALE_X: begin
                        dvd_next = DVW'(sw) << 16;
                        dsr_next = dw;
                    end
                    tr_pkg::JOB_SCALE_Y: begin
                        dvd_next = DVW'(sh) << 16;
                        dsr_next = dh;
                    end
                    tr_pkg::JOB_RECIP_X: begin
                        dvd_next = DVW'(1) << K;
                        dsr_next = dw;
                    end
                    default: begin
                        dvd_next = DVW'(1) << K;
                        dsr_next = dh;
                    end
                endcase
                state_next = tr_pkg::SETUP_RUN;
            end
            tr_pkg::SETUP_RUN: begin
                rem_next = ge ? trial - {1'b0, dsr_reg} : trial;
                dvd_next = quot;
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(DVW - 1)) begin
                    case (job_reg)
                        tr_pkg::JOB_SCALE_X: scale_x_next = quot[SCB-1:0];
                        tr_pkg::JOB_SCALE_Y: scale_y_next = quot[SCB-1:0];
                        tr_pkg::JOB_RECIP_X: recip_x_next = quot[RB-1:0];
                        default:             recip_y_next = quot[RB-1:0];
                    endcase
                    if (job_reg == tr_pkg::JOB_RECIP_Y) begin
                        state_next = tr_pkg::SETUP_IDLE;
                    end else begin
                        job_next   = tr_pkg::setup_job_t'(job_reg + 2'd1);
                        state_next = tr_pkg::SETUP_LOAD;
                    end
                end
            end
            default: begin
                state_next = tr_pkg::SETUP_IDLE;
            end
        endcase
        if (restart) begin
            state_next = tr_pkg::SETUP_LOAD;
            job_next   = tr_pkg::JOB_SCALE_X;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tr_pkg::SETUP_LOAD;
            job_reg   <= tr_pkg::JOB_SCALE_X;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        dsr_reg     <= dsr_next;
        scale_x_reg <= scale_x_next;
        scale_y_reg <= scale_y_next;
        recip_x_reg <= recip_x_next;
        recip_y_reg <= recip_y_next;
    end

    assign scale_x = scale_x_reg;
    assign scale_y = scale_y_reg;
    assign recip_x = recip_x_reg;
    assign recip_y = recip_y_reg;
    assign busy    = state_reg != tr_pkg::SETUP_IDLE;

endmodule

`default_nettype wire

// ===== design/tr_coord.sv =====
// Three-stage coordinate pipeline: destination to source positions, indices and weights.
`timescale 1ns / 1ps
`default_nettype none

module tr_coord #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int WEIGHT_BITS    = 8,
    parameter int SZW            = 9,
    parameter int DDW            = 11,
    parameter int SCB            = 25,
    parameter int RB             = 31,
    parameter int K              = 30,
    parameter int SXB            = 8,
    parameter int SYB            = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire tr_pkg::in_item_t       in_item,
    input  wire logic                   fmt16,
    input  wire logic                   filt,
    input  wire logic [SZW-1:0]         sw,
    input  wire logic [SZW-1:0]         sh,
    input  wire logic [DDW-1:0]         dw,
    input  wire logic [DDW-1:0]         dh,
    input  wire logic [SCB-1:0]         scale_x,
    input  wire logic [SCB-1:0]         scale_y,
    input  wire logic [RB-1:0]          recip_x,
    input  wire logic [RB-1:0]          recip_y,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output tr_pkg::meta_t               out_meta,
    output logic [SXB-1:0]              out_x0,
    output logic [SXB-1:0]              out_x1,
    output logic [SYB-1:0]              out_y0,
    output logic [SYB-1:0]              out_y1,
    output logic [WEIGHT_BITS-1:0]      out_tx,
    output logic [WEIGHT_BITS-1:0]      out_ty
);

    localparam int PRB = 11 + SCB;
    localparam int PB  = PRB - 1;
    localparam int NB  = 10 + SZW;
    localparam int MB  = NB + RB;
    localparam int CB  = NB + DDW;

    function automatic logic [31:0] lim(input logic [31:0] v, input logic [31:0] n);
        lim = (v > n - 32'd1) ? n - 32'd1 : v;
    endfunction

    logic rdy1, rdy2, rdy3;
    logic v1_reg, v2_reg, v3_reg;

    tr_pkg::meta_t    meta1_reg, meta1_next, meta2_reg, meta3_reg;
    logic [PRB-1:0]   prodx1_reg, prodx1_next, prody1_reg, prody1_next;
    logic [NB-1:0]    nx1_reg, nx1_next, ny1_reg, ny1_next;
    logic [PB-1:0]    posx2_reg, posx2_next, posy2_reg, posy2_next;
    logic [NB-1:0]    qx2_reg, qx2_next, qy2_reg, qy2_next, nx2_reg, ny2_reg;
    logic [SXB-1:0]   x0_3_reg, x0_3_next, x1_3_reg, x1_3_next;
    logic [SYB-1:0]   y0_3_reg, y0_3_next, y1_3_reg, y1_3_next;
    logic [WEIGHT_BITS-1:0] tx3_reg, tx3_next, ty3_reg, ty3_next;

    logic [PB-1:0]    halfx, halfy;
    logic [MB-1:0]    mulx, muly;
    logic [CB-1:0]    chkx, chky, remx, remy;
    logic [NB-1:0]    qx, qy;
    logic [PB:0]      nearx_sum, neary_sum;
    logic [PB-17:0]   ix0, iy0;
    logic             copy;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // First stage: products of the mapping and of the floor division.
    always_comb begin
        meta1_next.is_sample   = in_item.opcode == tr_pkg::OP_SAMPLE;
        meta1_next.load_ok     = in_item.opcode == tr_pkg::OP_LOAD
                              && 32'(in_item.coord_x) < 32'(MAX_SRC_WIDTH)
                              && 32'(in_item.coord_y) < 32'(MAX_SRC_HEIGHT);
        meta1_next.fmt16       = fmt16 == tr_pkg::FMT_A1R5G5B5;
        meta1_next.range_error = in_item.opcode == tr_pkg::OP_SAMPLE
                              && (32'(in_item.coord_x) >= 32'(dw)
                               || 32'(in_item.coord_y) >= 32'(dh));
        meta1_next.coord_x     = in_item.coord_x;
        meta1_next.coord_y     = in_item.coord_y;
        meta1_next.pixel       = in_item.pixel_in;
        prodx1_next = PRB'({in_item.coord_x, 1'b1}) * PRB'(scale_x);
        prody1_next = PRB'({in_item.coord_y, 1'b1}) * PRB'(scale_y);
        nx1_next    = NB'(in_item.coord_x) * NB'(sw);
        ny1_next    = NB'(in_item.coord_y) * NB'(sh);
    end

    // Second stage: centre-aligned position with negatives clamped, and the
    // reciprocal estimate of the floor quotient.
    always_comb begin
        halfx      = prodx1_reg[PRB-1:1];
        halfy      = prody1_reg[PRB-1:1];
        posx2_next = (halfx >= PB'(32768)) ? halfx - PB'(32768) : '0;
        posy2_next = (halfy >= PB'(32768)) ? halfy - PB'(32768) : '0;
        mulx       = MB'(nx1_reg) * MB'(recip_x);
        muly       = MB'(ny1_reg) * MB'(recip_y);
        qx2_next   = mulx[K +: NB];
        qy2_next   = muly[K +: NB];
    end

    // Third stage: quotient correction and choice of the neighbour indices.
    always_comb begin
        chkx = CB'(qx2_reg) * CB'(dw);
        chky = CB'(qy2_reg) * CB'(dh);
        remx = CB'(nx2_reg) - chkx;
        remy = CB'(ny2_reg) - chky;
        qx   = qx2_reg + NB'(remx >= CB'(dw));
        qy   = qy2_reg + NB'(remy >= CB'(dh));
        nearx_sum = (PB + 1)'(posx2_reg) + (PB + 1)'(32768);
        neary_sum = (PB + 1)'(posy2_reg) + (PB + 1)'(32768);
        ix0  = posx2_reg[PB-1:16];
        iy0  = posy2_reg[PB-1:16];
        copy = 32'(sw) == 32'(dw) && 32'(sh) == 32'(dh);
        tx3_next = '0;
        ty3_next = '0;
        if (copy) begin
            x0_3_next = SXB'(lim(32'(meta2_reg.coord_x), 32'(sw)));
            y0_3_next = SYB'(lim(32'(meta2_reg.coord_y), 32'(sh)));
            x1_3_next = x0_3_next;
            y1_3_next = y0_3_next;
        end else if (meta2_reg.fmt16) begin
            x0_3_next = SXB'(lim(32'(qx), 32'(sw)));
            y0_3_next = SYB'(lim(32'(qy), 32'(sh)));
            x1_3_next = x0_3_next;
            y1_3_next = y0_3_next;
        end else if (filt == tr_pkg::FILT_BILINEAR) begin
            x0_3_next = SXB'(lim(32'(ix0), 32'(sw)));
            y0_3_next = SYB'(lim(32'(iy0), 32'(sh)));
            x1_3_next = SXB'(lim(32'(ix0) + 32'd1, 32'(sw)));
            y1_3_next = SYB'(lim(32'(iy0) + 32'd1, 32'(sh)));
            tx3_next  = posx2_reg[15 -: WEIGHT_BITS];
            ty3_next  = posy2_reg[15 -: WEIGHT_BITS];
        end else begin
            x0_3_next = SXB'(lim(32'(nearx_sum[PB:16]), 32'(sw)));
            y0_3_next = SYB'(lim(32'(neary_sum[PB:16]), 32'(sh)));
            x1_3_next = x0_3_next;
            y1_3_next = y0_3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            meta1_reg  <= meta1_next;
            prodx1_reg <= prodx1_next;
            prody1_reg <= prody1_next;
            nx1_reg    <= nx1_next;
            ny1_reg    <= ny1_next;
        end
        if (rdy2) begin
            meta2_reg <= meta1_reg;
            posx2_reg <= posx2_next;
            posy2_reg <= posy2_next;
            qx2_reg   <= qx2_next;
            qy2_reg   <= qy2_next;
            nx2_reg   <= nx1_reg;
            ny2_reg   <= ny1_reg;
        end
        if (rdy3) begin
            meta3_reg <= meta2_reg;
            x0_3_reg  <= x0_3_next;
            x1_3_reg  <= x1_3_next;
            y0_3_reg  <= y0_3_next;
            y1_3_reg  <= y1_3_next;
            tx3_reg   <= tx3_next;
            ty3_reg   <= ty3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_meta  = meta3_reg;
    assign out_x0    = x0_3_reg;
    assign out_x1    = x1_3_reg;
    assign out_y0    = y0_3_reg;
    assign out_y1    = y1_3_reg;
    assign out_tx    = tx3_reg;
    assign out_ty    = ty3_reg;

endmodule

`default_nettype wire

// ===== design/tr_filter.sv =====
// Two-stage per-channel interpolation: horizontal lerps, then vertical lerp and output register.
`timescale 1ns / 1ps
`default_nettype none

module tr_filter #(
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire tr_pkg::meta_t          in_meta,
    input  wire logic [WEIGHT_BITS-1:0] in_tx,
    input  wire logic [WEIGHT_BITS-1:0] in_ty,
    input  wire logic [31:0]            c00,
    input  wire logic [31:0]            c10,
    input  wire logic [31:0]            c01,
    input  wire logic [31:0]            c11,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output tr_pkg::out_item_t           out_item
);

    localparam int AW = WEIGHT_BITS + 11;
    localparam logic signed [AW-1:0] LERP_HALF = AW'(1) << (WEIGHT_BITS - 1);

    // Signed difference, so a falling channel interpolates correctly.
    function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                        input logic [WEIGHT_BITS-1:0] t);
        logic signed [AW-1:0] acc;
        acc = $signed({3'b000, a, {WEIGHT_BITS{1'b0}}})
            + ($signed({1'b0, b}) - $signed({1'b0, a})) * $signed({1'b0, t})
            + LERP_HALF;
        lerp = acc[WEIGHT_BITS +: 8];
    endfunction

    logic rdy5, rdy6;
    logic v5_reg, v6_reg;
    tr_pkg::meta_t meta5_reg;
    logic [WEIGHT_BITS-1:0] ty5_reg;
    logic [31:0] top5_reg, top5_next, bot5_reg, bot5_next;
    tr_pkg::out_item_t item6_reg, item6_next;
    logic [31:0] pix;

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign in_ready = rdy5;

    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            top5_next[ch*8 +: 8] = lerp(c00[ch*8 +: 8], c10[ch*8 +: 8], in_tx);
            bot5_next[ch*8 +: 8] = lerp(c01[ch*8 +: 8], c11[ch*8 +: 8], in_tx);
        end
    end

    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            pix[ch*8 +: 8] = lerp(top5_reg[ch*8 +: 8], bot5_reg[ch*8 +: 8], ty5_reg);
        end
        if (meta5_reg.fmt16) begin
            pix[31:16] = '0;
        end
        if (meta5_reg.range_error) begin
            pix = '0;
        end
        item6_next.pixel_out   = pix;
        item6_next.out_x       = meta5_reg.coord_x;
        item6_next.out_y       = meta5_reg.coord_y;
        item6_next.range_error = meta5_reg.range_error;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy5) v5_reg <= in_valid;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            meta5_reg <= in_meta;
            ty5_reg   <= in_ty;
            top5_reg  <= top5_next;
            bot5_reg  <= bot5_next;
        end
        if (rdy6) begin
            item6_reg <= item6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_item  = item6_reg;

endmodule

`default_nettype wire

// ===== design/texture_resampler.sv =====
// Top level of the texture resampler: configuration, image store banks and pipeline glue.
`timescale 1ns / 1ps
`default_nettype none

// The resampler takes one item per clock cycle while s_ready is high, loads
// and samples alike, and delivers each sample's pixel through the pipeline
// stages to the output register; loads give no result. A load writes the
// source store at the same pipeline point where samples read it, so every
// sample sees exactly the loads that were accepted before it. The store is
// split into four banks by column and row parity, each with one write and
// one read port, which is what lets the four bilinear neighbours be fetched
// in the same cycle. The store holds nothing defined until a pixel is loaded.
// After reset, and after every write to one of the four size registers, a
// bit-serial divider derives the two SZW.16 scale factors and two reciprocals
// used for the 16-bit floor mapping in four successive divisions. During that
// time s_ready is low; configuration writes are taken in any cycle.
module texture_resampler #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 1024,
    parameter int WEIGHT_BITS    = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [10:0]       cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tr_pkg::in_item_t  s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tr_pkg::out_item_t      m_item
);

    localparam int MAX_SRC = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
    localparam int SZW = $clog2(MAX_SRC + 1);
    localparam int DDW = $clog2(MAX_DST_DIM + 1);
    localparam int SCB = SZW + 16;
    localparam int NB  = 10 + SZW;
    localparam int K   = NB + DDW;
    localparam int RB  = K + 1;
    localparam int SXB = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
    localparam int SYB = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int HALF_W = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BAW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // Configuration registers; the user must write them only while idle; not enforced.
    logic        pixel_format_reg, filter_mode_reg;
    logic [8:0]  src_width_reg, src_height_reg;
    logic [10:0] dst_width_reg, dst_height_reg;
    logic        size_write;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= tr_pkg::FMT_ARGB8888;
            filter_mode_reg  <= tr_pkg::FILT_BILINEAR;
            src_width_reg    <= 9'd256;
            src_height_reg   <= 9'd256;
            dst_width_reg    <= 11'd256;
            dst_height_reg   <= 11'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                tr_pkg::CFG_PIXEL_FORMAT: pixel_format_reg <= cfg_wdata[0];
                tr_pkg::CFG_FILTER_MODE:  filter_mode_reg  <= cfg_wdata[0];
                tr_pkg::CFG_SRC_WIDTH:    src_width_reg    <= cfg_wdata[8:0];
                tr_pkg::CFG_SRC_HEIGHT:   src_height_reg   <= cfg_wdata[8:0];
                tr_pkg::CFG_DST_WIDTH:    dst_width_reg    <= cfg_wdata;
                tr_pkg::CFG_DST_HEIGHT:   dst_height_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        size_write = cfg_we && (cfg_index inside {tr_pkg::CFG_SRC_WIDTH, tr_pkg::CFG_SRC_HEIGHT,
                                                  tr_pkg::CFG_DST_WIDTH, tr_pkg::CFG_DST_HEIGHT});
    end

    // Sizes as used: zero acts as one, and anything above the maximum acts as the maximum.
    logic [SZW-1:0] sw, sh;
    logic [DDW-1:0] dw, dh;

    always_comb begin
        if (src_width_reg == '0) sw = SZW'(1);
        else if (32'(src_width_reg) > 32'(MAX_SRC_WIDTH)) sw = SZW'(MAX_SRC_WIDTH);
        else sw = SZW'(src_width_reg);
        if (src_height_reg == '0) sh = SZW'(1);
        else if (32'(src_height_reg) > 32'(MAX_SRC_HEIGHT)) sh = SZW'(MAX_SRC_HEIGHT);
        else sh = SZW'(src_height_reg);
        if (dst_width_reg == '0) dw = DDW'(1);
        else if (32'(dst_width_reg) > 32'(MAX_DST_DIM)) dw = DDW'(MAX_DST_DIM);
        else dw = DDW'(dst_width_reg);
        if (dst_height_reg == '0) dh = DDW'(1);
        else if (32'(dst_height_reg) > 32'(MAX_DST_DIM)) dh = DDW'(MAX_DST_DIM);
        else dh = DDW'(dst_height_reg);
    end

    logic [SCB-1:0] scale_x, scale_y;
    logic [RB-1:0]  recip_x, recip_y;
    logic           busy;

    tr_setup #(
        .SZW(SZW), .DDW(DDW), .SCB(SCB), .RB(RB), .K(K)
    ) u_setup (
        .aclk(aclk), .aresetn(aresetn), .restart(size_write),
        .sw(sw), .sh(sh), .dw(dw), .dh(dh),
        .scale_x(scale_x), .scale_y(scale_y), .recip_x(recip_x), .recip_y(recip_y),
        .busy(busy)
    );

    // Coordinate pipeline, stages one to three.
    logic                   c_in_ready, c_valid, c_ready;
    tr_pkg::meta_t          c_meta;
    logic [SXB-1:0]         c_x0, c_x1;
    logic [SYB-1:0]         c_y0, c_y1;
    logic [WEIGHT_BITS-1:0] c_tx, c_ty;

    assign s_ready = c_in_ready && !busy;

    tr_coord #(
        .MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
        .WEIGHT_BITS(WEIGHT_BITS), .SZW(SZW), .DDW(DDW), .SCB(SCB), .RB(RB), .K(K),
        .SXB(SXB), .SYB(SYB)
    ) u_coord (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid && !busy), .in_ready(c_in_ready), .in_item(s_item),
        .fmt16(pixel_format_reg), .filt(filter_mode_reg),
        .sw(sw), .sh(sh), .dw(dw), .dh(dh),
        .scale_x(scale_x), .scale_y(scale_y), .recip_x(recip_x), .recip_y(recip_y),
        .out_valid(c_valid), .out_ready(c_ready), .out_meta(c_meta),
        .out_x0(c_x0), .out_x1(c_x1), .out_y0(c_y0), .out_y1(c_y1),
        .out_tx(c_tx), .out_ty(c_ty)
    );

    // Stage four: the store access. Loads write and leave the pipeline here;
    // samples read all four banks and their data appears with the stage register.
    logic                   v4_reg, rdy4, f_ready, adv4;
    tr_pkg::meta_t          meta4_reg;
    logic [WEIGHT_BITS-1:0] tx4_reg, ty4_reg;
    logic                   x0b4_reg, x1b4_reg, y0b4_reg, y1b4_reg;
    logic [31:0]            bank_rdata [4];

    assign rdy4    = !v4_reg || f_ready;
    assign c_ready = rdy4;
    assign adv4    = rdy4 && c_valid;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BX = 1'(b % 2);
        localparam logic BY = 1'(b / 2);
        logic [SXB-1:0] rcol;
        logic [SYB-1:0] rrow;
        logic [BAW-1:0] raddr, waddr;
        logic           we, re;

        always_comb begin
            rcol  = (BX == c_x0[0]) ? c_x0 : c_x1;
            rrow  = (BY == c_y0[0]) ? c_y0 : c_y1;
            raddr = BAW'(32'(rrow >> 1) * HALF_W + 32'(rcol >> 1));
            waddr = BAW'(32'(c_meta.coord_y >> 1) * HALF_W + 32'(c_meta.coord_x >> 1));
            we    = adv4 && c_meta.load_ok
                  && c_meta.coord_x[0] == BX && c_meta.coord_y[0] == BY;
            re    = adv4 && c_meta.is_sample;
        end

        tr_ram #(
            .WIDTH(32), .DEPTH(BANK_DEPTH)
        ) u_bank (
            .aclk(aclk), .we(we), .waddr(waddr), .wdata(c_meta.pixel),
            .re(re), .raddr(raddr), .rdata(bank_rdata[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= c_valid && c_meta.is_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            meta4_reg <= c_meta;
            tx4_reg   <= c_tx;
            ty4_reg   <= c_ty;
            x0b4_reg  <= c_x0[0];
            x1b4_reg  <= c_x1[0];
            y0b4_reg  <= c_y0[0];
            y1b4_reg  <= c_y1[0];
        end
    end

    // Stages five and six: interpolation and the output register.
    tr_filter #(
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_filter (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v4_reg), .in_ready(f_ready), .in_meta(meta4_reg),
        .in_tx(tx4_reg), .in_ty(ty4_reg),
        .c00(bank_rdata[{y0b4_reg, x0b4_reg}]),
        .c10(bank_rdata[{y0b4_reg, x1b4_reg}]),
        .c01(bank_rdata[{y1b4_reg, x0b4_reg}]),
        .c11(bank_rdata[{y1b4_reg, x1b4_reg}]),
        .out_valid(m_valid), .out_ready(m_ready), .out_item(m_item)
    );

endmodule

`default_nettype wire
